@@ rtl/rpfi_pkg.sv @@
// Shared types, constants and the microcode store for the ray and polygon fan intersector.
// Holds the transaction structs, the sequencer states and the saturating arithmetic helpers.
// Depends on nothing; every RTL file of the block refers to it by scoped names.
package rpfi_pkg;

  // Field and datapath widths.
  localparam int COORD_WIDTH = 32;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int DIST_W      = 31;
  localparam int VAL_W       = 64;
  localparam int PROD_W      = 2 * VAL_W;
  localparam int FRAC_BITS   = 12;
  localparam int DIR_BITS    = 30;
  localparam int Q_INT_BITS  = DIST_W - FRAC_BITS;
  localparam int MEM_DEPTH   = 32;
  localparam int MEM_AW      = $clog2(MEM_DEPTH);
  localparam int PC_W        = 7;
  localparam int MUL_CNT_W   = $clog2(VAL_W);
  localparam int DIV_CNT_W   = $clog2(DIST_W);

  localparam logic signed [VAL_W-1:0] SAT_POS = 64'sh1000_0000_0000_0000;
  localparam logic signed [VAL_W-1:0] SAT_NEG = -SAT_POS;
  localparam logic [DIST_W-1:0]       T_SAT   = {DIST_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_T_NEAR   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_T_FAR    = 3'd7;

  // Item kinds.
  localparam logic OP_PLANE  = 1'b0;
  localparam logic OP_VERTEX = 1'b1;

  typedef struct packed {
    logic                          op;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;
    logic signed [COORD_WIDTH-1:0] plane_offset;
    logic                          not_solid;
    logic                          last;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] hit_distance;
    logic              hit;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_EXEC, S_MUL, S_MULFIN, S_ACCUM,
    S_NEG, S_TEST, S_DIV, S_UPDATE, S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    UOP_END, UOP_MOV, UOP_SUB, UOP_MUL_LD, UOP_MUL_ADD, UOP_MUL_SUB,
    UOP_SAT_ADD, UOP_SAT_SUB, UOP_SAT_WR
  } uop_code_t;

  typedef logic [5:0]      uaddr_t;
  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    uop_code_t code;
    uaddr_t    a;
    uaddr_t    b;
    uaddr_t    dst;
    logic      shr30;
  } uop_t;

  // Operand space: ray registers, the held item, then the scratch memory (bit 5 set).
  localparam uaddr_t A_NONE   = 6'd0;
  localparam uaddr_t A_OX     = 6'd0;
  localparam uaddr_t A_OY     = 6'd1;
  localparam uaddr_t A_OZ     = 6'd2;
  localparam uaddr_t A_DX     = 6'd3;
  localparam uaddr_t A_DY     = 6'd4;
  localparam uaddr_t A_DZ     = 6'd5;
  localparam uaddr_t A_TFAR   = 6'd6;
  localparam uaddr_t A_CX     = 6'd8;
  localparam uaddr_t A_CY     = 6'd9;
  localparam uaddr_t A_CZ     = 6'd10;
  localparam uaddr_t A_W      = 6'd11;
  localparam uaddr_t A_FIRST0 = 6'd32;
  localparam uaddr_t A_FIRST1 = 6'd33;
  localparam uaddr_t A_FIRST2 = 6'd34;
  localparam uaddr_t A_PREV0  = 6'd35;
  localparam uaddr_t A_PREV1  = 6'd36;
  localparam uaddr_t A_PREV2  = 6'd37;
  localparam uaddr_t A_E1_0   = 6'd38;
  localparam uaddr_t A_E1_1   = 6'd39;
  localparam uaddr_t A_E1_2   = 6'd40;
  localparam uaddr_t A_E2_0   = 6'd41;
  localparam uaddr_t A_E2_1   = 6'd42;
  localparam uaddr_t A_E2_2   = 6'd43;
  localparam uaddr_t A_TV0    = 6'd44;
  localparam uaddr_t A_TV1    = 6'd45;
  localparam uaddr_t A_TV2    = 6'd46;
  localparam uaddr_t A_PV0    = 6'd47;
  localparam uaddr_t A_PV1    = 6'd48;
  localparam uaddr_t A_PV2    = 6'd49;
  localparam uaddr_t A_QV0    = 6'd50;
  localparam uaddr_t A_QV1    = 6'd51;
  localparam uaddr_t A_QV2    = 6'd52;
  localparam uaddr_t A_EP0    = 6'd53;
  localparam uaddr_t A_EP1    = 6'd54;
  localparam uaddr_t A_EP2    = 6'd55;

  // Scalar result registers, addressed with bit 5 clear.
  localparam uaddr_t D_DET = 6'd0;
  localparam uaddr_t D_NU  = 6'd1;
  localparam uaddr_t D_NV  = 6'd2;
  localparam uaddr_t D_NT  = 6'd3;
  localparam uaddr_t D_FS  = 6'd4;
  localparam uaddr_t D_TS  = 6'd5;

  // Program entry points.
  localparam pc_t PC_PLANE = 7'd0;
  localparam pc_t PC_FIRST = 7'd20;
  localparam pc_t PC_TRI   = 7'd24;
  localparam pc_t PC_PREV  = 7'd67;

  function automatic uop_t mk(uop_code_t c, uaddr_t a, uaddr_t b, uaddr_t d, logic s);
    uop_t u;
    u.code  = c;
    u.a     = a;
    u.b     = b;
    u.dst   = d;
    u.shr30 = s;
    return u;
  endfunction

  // Microcode: plane side tests, vertex stores and the Moller-Trumbore sums.
  function automatic uop_t uop_rom(pc_t pc);
    uop_t u;
    u = mk(UOP_END, A_NONE, A_NONE, A_NONE, 1'b0);
    case (pc)
      // Far end of the ray segment.
      7'd0:  u = mk(UOP_MUL_LD,  A_DX, A_TFAR, A_NONE, 1'b1);
      7'd1:  u = mk(UOP_SAT_ADD, A_OX, A_NONE, A_NONE, 1'b0);
      7'd2:  u = mk(UOP_SAT_WR,  A_NONE, A_NONE, A_EP0, 1'b0);
      7'd3:  u = mk(UOP_MUL_LD,  A_DY, A_TFAR, A_NONE, 1'b1);
      7'd4:  u = mk(UOP_SAT_ADD, A_OY, A_NONE, A_NONE, 1'b0);
      7'd5:  u = mk(UOP_SAT_WR,  A_NONE, A_NONE, A_EP1, 1'b0);
      7'd6:  u = mk(UOP_MUL_LD,  A_DZ, A_TFAR, A_NONE, 1'b1);
      7'd7:  u = mk(UOP_SAT_ADD, A_OZ, A_NONE, A_NONE, 1'b0);
      7'd8:  u = mk(UOP_SAT_WR,  A_NONE, A_NONE, A_EP2, 1'b0);
      // Plane side of the origin and of the far end.
      7'd9:  u = mk(UOP_MUL_LD,  A_CX, A_OX, A_NONE, 1'b0);
      7'd10: u = mk(UOP_MUL_ADD, A_CY, A_OY, A_NONE, 1'b0);
      7'd11: u = mk(UOP_MUL_ADD, A_CZ, A_OZ, A_NONE, 1'b0);
      7'd12: u = mk(UOP_SAT_SUB, A_W, A_NONE, A_NONE, 1'b0);
      7'd13: u = mk(UOP_SAT_WR,  A_NONE, A_NONE, D_FS, 1'b0);
      7'd14: u = mk(UOP_MUL_LD,  A_CX, A_EP0, A_NONE, 1'b0);
      7'd15: u = mk(UOP_MUL_ADD, A_CY, A_EP1, A_NONE, 1'b0);
      7'd16: u = mk(UOP_MUL_ADD, A_CZ, A_EP2, A_NONE, 1'b0);
      7'd17: u = mk(UOP_SAT_SUB, A_W, A_NONE, A_NONE, 1'b0);
      7'd18: u = mk(UOP_SAT_WR,  A_NONE, A_NONE, D_TS, 1'b0);
      7'd19: u = mk(UOP_END,     A_NONE, A_NONE, A_NONE, 1'b0);
      // First vertex of a fan.
      7'd20: u = mk(UOP_MOV, A_CX, A_NONE, A_FIRST0, 1'b0);
      7'd21: u = mk(UOP_MOV, A_CY, A_NONE, A_FIRST1, 1'b0);
      7'd22: u = mk(UOP_MOV, A_CZ, A_NONE, A_FIRST2, 1'b0);
      7'd23: u = mk(UOP_END, A_NONE, A_NONE, A_NONE, 1'b0);
      // Edges and origin offset.
      7'd24: u = mk(UOP_SUB, A_PREV0, A_FIRST0, A_E1_0, 1'b0);
      7'd25: u = mk(UOP_SUB, A_PREV1, A_FIRST1, A_E1_1, 1'b0);
      7'd26: u = mk(UOP_SUB, A_PREV2, A_FIRST2, A_E1_2, 1'b0);
      7'd27: u = mk(UOP_SUB, A_CX, A_FIRST0, A_E2_0, 1'b0);
      7'd28: u = mk(UOP_SUB, A_CY, A_FIRST1, A_E2_1, 1'b0);
      7'd29: u = mk(UOP_SUB, A_CZ, A_FIRST2, A_E2_2, 1'b0);
      7'd30: u = mk(UOP_SUB, A_OX, A_FIRST0, A_TV0, 1'b0);
      7'd31: u = mk(UOP_SUB, A_OY, A_FIRST1, A_TV1, 1'b0);
      7'd32: u = mk(UOP_SUB, A_OZ, A_FIRST2, A_TV2, 1'b0);
      // P = D x E2.
      7'd33: u = mk(UOP_MUL_LD,  A_DY, A_E2_2, A_NONE, 1'b1);
      7'd34: u = mk(UOP_MUL_SUB, A_DZ, A_E2_1, A_NONE, 1'b1);
      7'd35: u = mk(UOP_SAT_WR,  A_NONE, A_NONE, A_PV0, 1'b0);
      7'd36: u = mk(UOP_MUL_LD,  A_DZ, A_E2_0, A_NONE, 1'b1);
      7'd37: u = mk(UOP_MUL_SUB, A_DX, A_E2_2, A_NONE, 1'b1);
      7'd38: u = mk(UOP_SAT_WR,  A_NONE, A_NONE, A_PV1, 1'b0);
      7'd39: u = mk(UOP_MUL_LD,  A_DX, A_E2_1, A_NONE, 1'b1);
      7'd40: u = mk(UOP_MUL_SUB, A_DY, A_E2_0, A_NONE, 1'b1);
      7'd41: u = mk(UOP_SAT_WR,  A_NONE, A_NONE, A_PV2, 1'b0);
      // Determinant and u numerator.
      7'd42: u = mk(UOP_MUL_LD,  A_E1_0, A_PV0, A_NONE, 1'b0);
      7'd43: u = mk(UOP_MUL_ADD, A_E1_1, A_PV1, A_NONE, 1'b0);
      7'd44: u = mk(UOP_MUL_ADD, A_E1_2, A_PV2, A_NONE, 1'b0);
      7'd45: u = mk(UOP_SAT_WR,  A_NONE, A_NONE, D_DET, 1'b0);
      7'd46: u = mk(UOP_MUL_LD,  A_TV0, A_PV0, A_NONE, 1'b0);
      7'd47: u = mk(UOP_MUL_ADD, A_TV1, A_PV1, A_NONE, 1'b0);
      7'd48: u = mk(UOP_MUL_ADD, A_TV2, A_PV2, A_NONE, 1'b0);
      7'd49: u = mk(UOP_SAT_WR,  A_NONE, A_NONE, D_NU, 1'b0);
      // Q = T x E1.
      7'd50: u = mk(UOP_MUL_LD,  A_TV1, A_E1_2, A_NONE, 1'b0);
      7'd51: u = mk(UOP_MUL_SUB, A_TV2, A_E1_1, A_NONE, 1'b0);
      7'd52: u = mk(UOP_SAT_WR,  A_NONE, A_NONE, A_QV0, 1'b0);
      7'd53: u = mk(UOP_MUL_LD,  A_TV2, A_E1_0, A_NONE, 1'b0);
      7'd54: u = mk(UOP_MUL_SUB, A_TV0, A_E1_2, A_NONE, 1'b0);
      7'd55: u = mk(UOP_SAT_WR,  A_NONE, A_NONE, A_QV1, 1'b0);
      7'd56: u = mk(UOP_MUL_LD,  A_TV0, A_E1_1, A_NONE, 1'b0);
      7'd57: u = mk(UOP_MUL_SUB, A_TV1, A_E1_0, A_NONE, 1'b0);
      7'd58: u = mk(UOP_SAT_WR,  A_NONE, A_NONE, A_QV2, 1'b0);
      // v and t numerators.
      7'd59: u = mk(UOP_MUL_LD,  A_DX, A_QV0, A_NONE, 1'b1);
      7'd60: u = mk(UOP_MUL_ADD, A_DY, A_QV1, A_NONE, 1'b1);
      7'd61: u = mk(UOP_MUL_ADD, A_DZ, A_QV2, A_NONE, 1'b1);
      7'd62: u = mk(UOP_SAT_WR,  A_NONE, A_NONE, D_NV, 1'b0);
      7'd63: u = mk(UOP_MUL_LD,  A_E2_0, A_QV0, A_NONE, 1'b0);
      7'd64: u = mk(UOP_MUL_ADD, A_E2_1, A_QV1, A_NONE, 1'b0);
      7'd65: u = mk(UOP_MUL_ADD, A_E2_2, A_QV2, A_NONE, 1'b0);
      7'd66: u = mk(UOP_SAT_WR,  A_NONE, A_NONE, D_NT, 1'b0);
      // Current vertex becomes the previous one.
      7'd67: u = mk(UOP_MOV, A_CX, A_NONE, A_PREV0, 1'b0);
      7'd68: u = mk(UOP_MOV, A_CY, A_NONE, A_PREV1, 1'b0);
      7'd69: u = mk(UOP_MOV, A_CZ, A_NONE, A_PREV2, 1'b0);
      default: u = mk(UOP_END, A_NONE, A_NONE, A_NONE, 1'b0);
    endcase
    return u;
  endfunction

  // Clamp to plus or minus 2^60.
  function automatic logic signed [VAL_W-1:0] sat60(logic signed [VAL_W-1:0] x);
    logic signed [VAL_W-1:0] r;
    r = x;
    if (x > SAT_POS) r = SAT_POS;
    if (x < SAT_NEG) r = SAT_NEG;
    return r;
  endfunction

  // Floor shift of an unsigned product magnitude, sign applied, then clamped.
  function automatic logic signed [VAL_W-1:0] mul_finish(logic [PROD_W-1:0] prod,
                                                        logic s30, logic neg);
    logic [PROD_W-1:0] q;
    logic [PROD_W-1:0] q2;
    logic              rem;
    logic [VAL_W-1:0]  mag;
    q   = s30 ? (prod >> DIR_BITS) : (prod >> FRAC_BITS);
    rem = s30 ? (|prod[DIR_BITS-1:0]) : (|prod[FRAC_BITS-1:0]);
    q2  = q + PROD_W'(neg & rem);
    mag = (q2 > PROD_W'(SAT_POS)) ? SAT_POS : q2[VAL_W-1:0];
    return neg ? -signed'(mag) : signed'(mag);
  endfunction

endpackage

@@ rtl/ray_polygon_fan_intersect.sv @@
// Ray against convex polygon fans: top level with sequencer, multiplier and divider (rpfi_pkg).
// Each product runs through a 64-step shift-add multiplier, plus fetch and fold; a fan vertex
// computes 24 products and may run a 31-step restoring divider; a last vertex waits for the output.
// One transaction is worked on at a time; the result register frees the input side.
// Synchronous active-high reset clears control state and restores the ray registers.
module ray_polygon_fan_intersect (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  rpfi_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output rpfi_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [rpfi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rpfi_pkg::CFG_W-1:0]         cfg_data
);

  localparam int VW = rpfi_pkg::VAL_W;
  localparam int CW = rpfi_pkg::COORD_WIDTH;
  localparam int DW = rpfi_pkg::DIST_W;

  // Ray registers.
  logic [rpfi_pkg::CFG_W-1:0] origin_x, origin_y, origin_z;
  logic [rpfi_pkg::CFG_W-1:0] dir_x, dir_y, dir_z;
  logic [DW-1:0]              t_near, t_far;

  // Control state.
  rpfi_pkg::state_t   state, state_next;
  rpfi_pkg::pc_t      pc;
  rpfi_pkg::uop_t     uop;
  rpfi_pkg::in_item_t hold;
  logic [1:0]         vtx_count;
  logic               skip_poly;
  logic               run_tri;
  logic [DW-1:0]      best;

  // Scratch memory.
  logic signed [VW-1:0]             mem [rpfi_pkg::MEM_DEPTH];
  logic signed [VW-1:0]             rd_a, rd_b;
  logic                             mem_we;
  logic [rpfi_pkg::MEM_AW-1:0]      mem_waddr;
  logic signed [VW-1:0]             mem_wdata;

  // Arithmetic.
  logic signed [VW-1:0]             opa, opb;
  logic signed [VW-1:0]             acc;
  logic [VW-1:0]                    mul_a, mul_hi, mul_lo;
  logic                             mul_neg;
  logic [rpfi_pkg::MUL_CNT_W-1:0]   mul_cnt;
  logic [VW:0]                      mul_sum;
  logic signed [VW-1:0]             mul_p;
  logic signed [VW-1:0]             sc_det, sc_nu, sc_nv, sc_nt, sc_fs, sc_ts;
  logic signed [VW-1:0]             sat_acc;
  logic                             test_miss, test_sat;
  logic [VW-1:0]                    div_rem;
  logic [VW-1:0]                    div_shift;
  logic [DW-1:0]                    div_num;
  logic [DW-1:0]                    div_q;
  logic [rpfi_pkg::DIV_CNT_W-1:0]   div_cnt;
  logic [DW-1:0]                    t_clamp;
  logic [DW-1:0]                    emit_dist;
  logic                             out_free;

  // Operand selection over ray registers, the held item and the scratch memory.
  function automatic logic signed [VW-1:0] operand(rpfi_pkg::uaddr_t a,
                                                  logic signed [VW-1:0] rd);
    logic signed [VW-1:0] v;
    v = rd;
    unique case (a)
      rpfi_pkg::A_OX:   v = VW'(signed'(CW'(origin_x)));
      rpfi_pkg::A_OY:   v = VW'(signed'(CW'(origin_y)));
      rpfi_pkg::A_OZ:   v = VW'(signed'(CW'(origin_z)));
      rpfi_pkg::A_DX:   v = VW'(signed'(dir_x));
      rpfi_pkg::A_DY:   v = VW'(signed'(dir_y));
      rpfi_pkg::A_DZ:   v = VW'(signed'(dir_z));
      rpfi_pkg::A_TFAR: v = signed'(VW'(t_far));
      rpfi_pkg::A_CX:   v = VW'(hold.coord_x);
      rpfi_pkg::A_CY:   v = VW'(hold.coord_y);
      rpfi_pkg::A_CZ:   v = VW'(hold.coord_z);
      rpfi_pkg::A_W:    v = VW'(hold.plane_offset);
      default:          v = rd;
    endcase
    return v;
  endfunction

  function automatic logic [VW-1:0] magnitude(logic signed [VW-1:0] x);
    return x[VW-1] ? unsigned'(-x) : unsigned'(x);
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      origin_z <= '0;
      dir_x    <= 32'h4000_0000;
      dir_y    <= '0;
      dir_z    <= '0;
      t_near   <= '0;
      t_far    <= rpfi_pkg::T_SAT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rpfi_pkg::CFG_ORIGIN_X: origin_x <= cfg_data;
        rpfi_pkg::CFG_ORIGIN_Y: origin_y <= cfg_data;
        rpfi_pkg::CFG_ORIGIN_Z: origin_z <= cfg_data;
        rpfi_pkg::CFG_DIR_X:    dir_x    <= cfg_data;
        rpfi_pkg::CFG_DIR_Y:    dir_y    <= cfg_data;
        rpfi_pkg::CFG_DIR_Z:    dir_z    <= cfg_data;
        rpfi_pkg::CFG_T_NEAR:   t_near   <= cfg_data[DW-1:0];
        rpfi_pkg::CFG_T_FAR:    t_far    <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  // Combinational datapath terms.
  always_comb begin
    uop       = rpfi_pkg::uop_rom(pc);
    opa       = operand(uop.a, rd_a);
    opb       = operand(uop.b, rd_b);
    sat_acc   = rpfi_pkg::sat60(acc);
    mul_sum   = {1'b0, mul_hi} + (mul_lo[0] ? {1'b0, mul_a} : '0);
    div_shift = {div_rem[VW-2:0], div_num[DW-1]};
    test_miss = (sc_det == '0) || (sc_nu < 0) || (sc_nu > sc_det) || (sc_nv < 0) ||
                ((sc_nu + sc_nv) > sc_det) || (sc_nt <= 0);
    test_sat  = {32'd0, sc_nt} >= ({32'd0, sc_det} << rpfi_pkg::Q_INT_BITS);
    t_clamp   = (div_q == '0) ? t_far : ((div_q < t_far) ? div_q : t_far);
    emit_dist = skip_poly ? t_far : best;
    out_free  = !out_valid || out_ready;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rpfi_pkg::S_IDLE:   if (in_valid) state_next = rpfi_pkg::S_FETCH;
      rpfi_pkg::S_FETCH:  state_next = rpfi_pkg::S_EXEC;
      rpfi_pkg::S_EXEC: begin
        case (uop.code) inside
          rpfi_pkg::UOP_MUL_LD, rpfi_pkg::UOP_MUL_ADD, rpfi_pkg::UOP_MUL_SUB:
            state_next = rpfi_pkg::S_MUL;
          rpfi_pkg::UOP_END: begin
            if (hold.op == rpfi_pkg::OP_PLANE) state_next = rpfi_pkg::S_IDLE;
            else if (run_tri)                  state_next = rpfi_pkg::S_NEG;
            else                               state_next = rpfi_pkg::S_EMIT;
          end
          default: state_next = rpfi_pkg::S_FETCH;
        endcase
      end
      rpfi_pkg::S_MUL:
        if (mul_cnt == rpfi_pkg::MUL_CNT_W'(VW - 1)) state_next = rpfi_pkg::S_MULFIN;
      rpfi_pkg::S_MULFIN: state_next = rpfi_pkg::S_ACCUM;
      rpfi_pkg::S_ACCUM:  state_next = rpfi_pkg::S_FETCH;
      rpfi_pkg::S_NEG:    state_next = rpfi_pkg::S_TEST;
      rpfi_pkg::S_TEST:
        state_next = (test_miss || test_sat) ? rpfi_pkg::S_UPDATE : rpfi_pkg::S_DIV;
      rpfi_pkg::S_DIV:
        if (div_cnt == rpfi_pkg::DIV_CNT_W'(DW - 1)) state_next = rpfi_pkg::S_UPDATE;
      rpfi_pkg::S_UPDATE: state_next = rpfi_pkg::S_EMIT;
      rpfi_pkg::S_EMIT:
        if (!hold.last || out_free) state_next = rpfi_pkg::S_IDLE;
      default: state_next = rpfi_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and memory write port.
  always_comb begin
    in_ready  = (state == rpfi_pkg::S_IDLE);
    mem_we    = 1'b0;
    mem_waddr = uop.dst[rpfi_pkg::MEM_AW-1:0];
    mem_wdata = opa;
    if (state == rpfi_pkg::S_EXEC) begin
      case (uop.code)
        rpfi_pkg::UOP_MOV: begin
          mem_we    = 1'b1;
          mem_wdata = opa;
        end
        rpfi_pkg::UOP_SUB: begin
          mem_we    = 1'b1;
          mem_wdata = opa - opb;
        end
        rpfi_pkg::UOP_SAT_WR: begin
          mem_we    = uop.dst[5];
          mem_wdata = sat_acc;
        end
        default: ;
      endcase
    end
  end

  // Scratch memory with registered reads.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_a <= mem[uop.a[rpfi_pkg::MEM_AW-1:0]];
    rd_b <= mem[uop.b[rpfi_pkg::MEM_AW-1:0]];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= rpfi_pkg::S_IDLE;
    else     state <= state_next;
  end

  // Polygon bookkeeping, sequencer counter and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= rpfi_pkg::PC_PLANE;
      vtx_count <= '0;
      skip_poly <= 1'b0;
      run_tri   <= 1'b0;
      best      <= rpfi_pkg::T_SAT;
      out_valid <= 1'b0;
    end else begin
      // A result taken in the same cycle as a new one is loaded is replaced, not cleared.
      if (out_valid && out_ready && !(state == rpfi_pkg::S_EMIT && hold.last))
        out_valid <= 1'b0;
      unique case (state)
        rpfi_pkg::S_IDLE: begin
          if (in_valid) begin
            run_tri <= 1'b0;
            if (in_data.op == rpfi_pkg::OP_PLANE) begin
              pc        <= rpfi_pkg::PC_PLANE;
              vtx_count <= '0;
              best      <= t_far;
            end else if (vtx_count == 2'd0) begin
              pc        <= rpfi_pkg::PC_FIRST;
              vtx_count <= 2'd1;
            end else if (vtx_count == 2'd1) begin
              pc        <= rpfi_pkg::PC_PREV;
              vtx_count <= 2'd2;
            end else begin
              pc      <= skip_poly ? rpfi_pkg::PC_PREV : rpfi_pkg::PC_TRI;
              run_tri <= !skip_poly;
            end
          end
        end
        rpfi_pkg::S_EXEC: begin
          case (uop.code) inside
            rpfi_pkg::UOP_MUL_LD, rpfi_pkg::UOP_MUL_ADD, rpfi_pkg::UOP_MUL_SUB: ;
            rpfi_pkg::UOP_END: begin
              if (hold.op == rpfi_pkg::OP_PLANE)
                skip_poly <= hold.not_solid || (sc_fs > 0 && sc_ts > 0) ||
                             (sc_fs < 0 && sc_ts < 0);
            end
            default: pc <= pc + 1'b1;
          endcase
        end
        rpfi_pkg::S_ACCUM: pc <= pc + 1'b1;
        rpfi_pkg::S_UPDATE: begin
          if (t_clamp >= t_near && t_clamp < best) best <= t_clamp;
        end
        rpfi_pkg::S_EMIT: begin
          if (hold.last && out_free) begin
            out_valid             <= 1'b1;
            out_data.hit_distance <= emit_dist;
            out_data.hit          <= emit_dist < t_far;
            vtx_count             <= '0;
            best                  <= t_far;
          end
        end
        default: ;
      endcase
    end
  end

  // Held transaction, multiplier, accumulator, scalar results and divider.
  always_ff @(posedge clk) begin
    if (state == rpfi_pkg::S_IDLE && in_valid) hold <= in_data;

    if (state == rpfi_pkg::S_EXEC) begin
      case (uop.code) inside
        rpfi_pkg::UOP_MUL_LD, rpfi_pkg::UOP_MUL_ADD, rpfi_pkg::UOP_MUL_SUB: begin
          mul_a   <= magnitude(opa);
          mul_lo  <= magnitude(opb);
          mul_hi  <= '0;
          mul_neg <= opa[VW-1] ^ opb[VW-1];
          mul_cnt <= '0;
        end
        rpfi_pkg::UOP_SAT_ADD: acc <= sat_acc + opa;
        rpfi_pkg::UOP_SAT_SUB: acc <= sat_acc - opa;
        rpfi_pkg::UOP_SAT_WR: begin
          case (uop.dst)
            rpfi_pkg::D_DET: sc_det <= sat_acc;
            rpfi_pkg::D_NU:  sc_nu  <= sat_acc;
            rpfi_pkg::D_NV:  sc_nv  <= sat_acc;
            rpfi_pkg::D_NT:  sc_nt  <= sat_acc;
            rpfi_pkg::D_FS:  sc_fs  <= sat_acc;
            rpfi_pkg::D_TS:  sc_ts  <= sat_acc;
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    // One multiplier bit per cycle, product shifting down into the low word.
    if (state == rpfi_pkg::S_MUL) begin
      mul_hi  <= mul_sum[VW:1];
      mul_lo  <= {mul_sum[0], mul_lo[VW-1:1]};
      mul_cnt <= mul_cnt + 1'b1;
    end

    if (state == rpfi_pkg::S_MULFIN)
      mul_p <= rpfi_pkg::mul_finish({mul_hi, mul_lo}, uop.shr30, mul_neg);

    if (state == rpfi_pkg::S_ACCUM) begin
      case (uop.code)
        rpfi_pkg::UOP_MUL_ADD: acc <= acc + mul_p;
        rpfi_pkg::UOP_MUL_SUB: acc <= acc - mul_p;
        default:               acc <= mul_p;
      endcase
    end

    // Bring the determinant positive, carrying the numerators along.
    if (state == rpfi_pkg::S_NEG && sc_det < 0) begin
      sc_det <= -sc_det;
      sc_nu  <= -sc_nu;
      sc_nv  <= -sc_nv;
      sc_nt  <= -sc_nt;
    end

    // Set up the divider; a miss leaves zero and an overflow the saturated distance.
    if (state == rpfi_pkg::S_TEST) begin
      div_cnt <= '0;
      div_rem <= unsigned'(sc_nt) >> rpfi_pkg::Q_INT_BITS;
      div_num <= {sc_nt[rpfi_pkg::Q_INT_BITS-1:0], rpfi_pkg::FRAC_BITS'(0)};
      if (test_miss)     div_q <= '0;
      else if (test_sat) div_q <= rpfi_pkg::T_SAT;
      else               div_q <= '0;
    end

    // Restoring division, one quotient bit per cycle.
    if (state == rpfi_pkg::S_DIV) begin
      div_num <= div_num << 1;
      div_cnt <= div_cnt + 1'b1;
      if (div_shift >= unsigned'(sc_det)) begin
        div_rem <= div_shift - unsigned'(sc_det);
        div_q   <= {div_q[DW-2:0], 1'b1};
      end else begin
        div_rem <= div_shift;
        div_q   <= {div_q[DW-2:0], 1'b0};
      end
    end
  end

  // The partial remainder always stays below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == rpfi_pkg::S_DIV |-> (div_rem < unsigned'(sc_det)) && (sc_det > 0))
    else $error("divider remainder not below determinant");

  // The vertex count never passes two.
  a_vtx_count: assert property (@(posedge clk) disable iff (rst)
    vtx_count != 2'd3)
    else $error("vertex count out of range");

  // A last vertex with a free result register yields a result next cycle.
  a_emit: assert property (@(posedge clk) disable iff (rst)
    (state == rpfi_pkg::S_EMIT && hold.last && out_free) |=> out_valid)
    else $error("result not presented after last vertex");

  // An accepted transaction starts the microcode.
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == rpfi_pkg::S_FETCH)
    else $error("accepted transaction did not start the sequencer");

endmodule

@@ dv/ray_polygon_fan_intersect_checker.sv @@
// Scoreboard for the ray and polygon fan intersector: watches the item, result and register ports.
// Predicts each result from the item transactions in fixed point and compares it field by field.
// Depends on rpfi_pkg for the transaction structs and the register indexes.
module ray_polygon_fan_intersect_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  rpfi_pkg::in_item_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  rpfi_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [rpfi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpfi_pkg::CFG_W-1:0]     cfg_data,
  output int                             errors,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint triple_t [3];

  localparam longint CLAMP = 64'sh1000_0000_0000_0000;

  // Ray registers as the block holds them.
  longint      ray_origin [3];
  longint      ray_dir [3];
  logic [30:0] t_near_reg;
  logic [30:0] t_far_reg;

  // Polygon progress.
  logic        skip_poly;
  triple_t     fan_first;
  triple_t     fan_prev;
  int          fan_count;
  logic [30:0] nearest;

  rpfi_pkg::out_item_t expected_hits [$];
  int                  fail_count;

  function automatic longint clamp60(longint x);
    if (x > CLAMP) return CLAMP;
    if (x < -CLAMP) return -CLAMP;
    return x;
  endfunction

  // Exact product, floor shift, then clamp.
  function automatic longint mul_floor(longint a, longint b, int s);
    logic signed [127:0] pa, pb, p;
    pa = a;
    pb = b;
    p  = (pa * pb) >>> s;
    if (p > CLAMP) return CLAMP;
    if (p < -CLAMP) return -CLAMP;
    return longint'(p);
  endfunction

  function automatic longint dot3(triple_t a, triple_t b, int s);
    return clamp60(mul_floor(a[0], b[0], s) + mul_floor(a[1], b[1], s) + mul_floor(a[2], b[2], s));
  endfunction

  function automatic void cross3(triple_t a, triple_t b, int s, output triple_t r);
    r[0] = clamp60(mul_floor(a[1], b[2], s) - mul_floor(a[2], b[1], s));
    r[1] = clamp60(mul_floor(a[2], b[0], s) - mul_floor(a[0], b[2], s));
    r[2] = clamp60(mul_floor(a[0], b[1], s) - mul_floor(a[1], b[0], s));
  endfunction

  // Moller-Trumbore distance for one fan triangle; the ray length on a miss.
  function automatic logic [30:0] triangle_distance(triple_t a, triple_t b, triple_t c);
    triple_t     o, d, e1, e2, tv, pv, qv;
    longint      det, nu, nv, nt, q, r;
    logic [63:0] t;
    for (int i = 0; i < 3; i++) begin
      o[i]  = ray_origin[i];
      d[i]  = ray_dir[i];
      e1[i] = b[i] - a[i];
      e2[i] = c[i] - a[i];
      tv[i] = o[i] - a[i];
    end
    cross3(d, e2, rpfi_pkg::DIR_BITS, pv);
    det = dot3(e1, pv, rpfi_pkg::FRAC_BITS);
    if (det == 0) return t_far_reg;
    nu = dot3(tv, pv, rpfi_pkg::FRAC_BITS);
    cross3(tv, e1, rpfi_pkg::FRAC_BITS, qv);
    nv = dot3(d, qv, rpfi_pkg::DIR_BITS);
    nt = dot3(e2, qv, rpfi_pkg::FRAC_BITS);
    if (det < 0) begin
      det = -det;
      nu  = -nu;
      nv  = -nv;
      nt  = -nt;
    end
    if (nu < 0 || nu > det) return t_far_reg;
    if (nv < 0 || nu + nv > det) return t_far_reg;
    if (nt <= 0) return t_far_reg;
    q = nt / det;
    r = nt % det;
    if (q >= (64'sd1 <<< (31 - rpfi_pkg::FRAC_BITS))) begin
      t = 64'h7FFF_FFFF;
    end else begin
      t = q;
      for (int i = 0; i < rpfi_pkg::FRAC_BITS; i++) begin
        r = r <<< 1;
        t = t << 1;
        if (r >= det) begin
          r    = r - det;
          t[0] = 1'b1;
        end
      end
    end
    if (t == 0) return t_far_reg;
    return (t < t_far_reg) ? t[30:0] : t_far_reg;
  endfunction

  // Plane transaction: decide whether the segment crosses the plane.
  function automatic void take_plane(rpfi_pkg::in_item_t it);
    triple_t c, o, e;
    longint  w, fs, ts;
    c = '{longint'(it.coord_x), longint'(it.coord_y), longint'(it.coord_z)};
    w = it.plane_offset;
    for (int i = 0; i < 3; i++) begin
      o[i] = ray_origin[i];
      e[i] = clamp60(o[i] + mul_floor(ray_dir[i], longint'(t_far_reg), rpfi_pkg::DIR_BITS));
    end
    fs = clamp60(dot3(c, o, rpfi_pkg::FRAC_BITS) - w);
    ts = clamp60(dot3(c, e, rpfi_pkg::FRAC_BITS) - w);
    skip_poly = it.not_solid || (fs > 0 && ts > 0) || (fs < 0 && ts < 0);
    fan_count = 0;
    nearest   = t_far_reg;
  endfunction

  // Vertex transaction: extend the fan and queue a result on the closing vertex.
  function automatic void take_vertex(rpfi_pkg::in_item_t it);
    triple_t             c;
    logic [30:0]         tri_len;
    rpfi_pkg::out_item_t exp_item;
    c = '{longint'(it.coord_x), longint'(it.coord_y), longint'(it.coord_z)};
    if (fan_count == 0) begin
      fan_first = c;
      fan_count = 1;
    end else if (fan_count == 1) begin
      fan_prev  = c;
      fan_count = 2;
    end else begin
      if (!skip_poly) begin
        tri_len = triangle_distance(fan_first, fan_prev, c);
        if (tri_len >= t_near_reg && tri_len < nearest) nearest = tri_len;
      end
      fan_prev = c;
    end
    if (it.last) begin
      exp_item.hit_distance = skip_poly ? t_far_reg : nearest;
      exp_item.hit          = exp_item.hit_distance < t_far_reg;
      expected_hits.insert(expected_hits.size(), exp_item);
      fan_count = 0;
      nearest   = t_far_reg;
    end
  endfunction

  always @(posedge clk) begin
    rpfi_pkg::out_item_t want;
    if (rst) begin
      ray_origin = '{0, 0, 0};
      ray_dir    = '{longint'(32'sh4000_0000), 0, 0};
      t_near_reg = '0;
      t_far_reg  = rpfi_pkg::T_SAT;
      skip_poly  = 1'b0;
      fan_count  = 0;
      nearest    = rpfi_pkg::T_SAT;
      expected_hits.delete();
      fail_count = 0;
    end else begin
      // Register writes.
      if (cfg_we) begin
        case (cfg_index)
          rpfi_pkg::CFG_ORIGIN_X: ray_origin[0] = longint'(signed'(cfg_data));
          rpfi_pkg::CFG_ORIGIN_Y: ray_origin[1] = longint'(signed'(cfg_data));
          rpfi_pkg::CFG_ORIGIN_Z: ray_origin[2] = longint'(signed'(cfg_data));
          rpfi_pkg::CFG_DIR_X:    ray_dir[0]    = longint'(signed'(cfg_data));
          rpfi_pkg::CFG_DIR_Y:    ray_dir[1]    = longint'(signed'(cfg_data));
          rpfi_pkg::CFG_DIR_Z:    ray_dir[2]    = longint'(signed'(cfg_data));
          rpfi_pkg::CFG_T_NEAR:   t_near_reg    = cfg_data[30:0];
          rpfi_pkg::CFG_T_FAR:    t_far_reg     = cfg_data[30:0];
          default: ;
        endcase
      end
      // Result transactions against the oldest prediction.
      if (out_valid && out_ready) begin
        if (expected_hits.size() == 0) begin
          $error("result with nothing expected: hit_distance %0d hit %0d",
                 out_data.hit_distance, out_data.hit);
          fail_count++;
        end else begin
          want = expected_hits.pop_front();
          if (out_data.hit_distance !== want.hit_distance) begin
            $error("hit_distance: expected %0d, actual %0d", want.hit_distance,
                   out_data.hit_distance);
            fail_count++;
          end
          if (out_data.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, out_data.hit);
            fail_count++;
          end
        end
      end
      // Item transactions.
      if (in_valid && in_ready) begin
        if (in_data.op == rpfi_pkg::OP_PLANE) take_plane(in_data);
        else take_vertex(in_data);
      end
    end
    errors  <= fail_count;
    pending <= expected_hits.size();
  end

endmodule

@@ dv/ray_polygon_fan_intersect_test.sv @@
// Top of the intersector testbench: clock, reset, item and register stimulus, verdict.
// Depends on rpfi_pkg, the block ray_polygon_fan_intersect and ray_polygon_fan_intersect_checker.
module ray_polygon_fan_intersect_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     K          = 4096;
  localparam int     SETTLE     = 2500;
  localparam longint CYCLE_CAP  = 12_000_000;
  localparam int     PHASE_ITEMS = 150;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  rpfi_pkg::in_item_t             in_data;
  logic                           out_valid;
  logic                           out_ready;
  rpfi_pkg::out_item_t            out_data;
  logic                           cfg_we;
  logic [rpfi_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rpfi_pkg::CFG_W-1:0]     cfg_data;
  int                             errors;
  int                             pending;

  // Stimulus copy of the ray, used to aim polygons at it.
  longint               aim_origin [3];
  longint               aim_dir [3];
  logic                 steady;
  longint               cycle_count;
  int                   sent;

  ray_polygon_fan_intersect u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ray_polygon_fan_intersect_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 36);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("FAIL ray_polygon_fan_intersect");
      $finish;
    end
  end

  function automatic rpfi_pkg::in_item_t mk_item(logic op, longint x, longint y, longint z,
                                                 longint w, logic ns, logic lst);
    rpfi_pkg::in_item_t it;
    it.op           = op;
    it.coord_x      = x[31:0];
    it.coord_y      = y[31:0];
    it.coord_z      = z[31:0];
    it.plane_offset = w[31:0];
    it.not_solid    = ns;
    it.last         = lst;
    return it;
  endfunction

  // Random gaps, then one transaction held until accepted.
  task automatic send(rpfi_pkg::in_item_t it);
    while (!steady && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk iff in_ready);
    sent++;
  endtask

  // Let every expected result arrive and any silent work drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [rpfi_pkg::CFG_IDX_W-1:0] idx, longint v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v[31:0];
    @(posedge clk);
  endtask

  task automatic set_ray(longint ox, longint oy, longint oz, longint dx, longint dy,
                         longint dz, longint tn, longint tf);
    write_reg(rpfi_pkg::CFG_ORIGIN_X, ox);
    write_reg(rpfi_pkg::CFG_ORIGIN_Y, oy);
    write_reg(rpfi_pkg::CFG_ORIGIN_Z, oz);
    write_reg(rpfi_pkg::CFG_DIR_X, dx);
    write_reg(rpfi_pkg::CFG_DIR_Y, dy);
    write_reg(rpfi_pkg::CFG_DIR_Z, dz);
    write_reg(rpfi_pkg::CFG_T_NEAR, tn);
    write_reg(rpfi_pkg::CFG_T_FAR, tf);
    cfg_we <= 1'b0;
    aim_origin = '{longint'(signed'(ox[31:0])), longint'(signed'(oy[31:0])),
                   longint'(signed'(oz[31:0]))};
    aim_dir    = '{dx, dy, dz};
  endtask

  // A polygon facing the ray around the point at distance t, vertices scattered around it.
  task automatic send_polygon();
    longint t, spread, w;
    longint centre [3];
    longint nrm [3];
    int     nv;
    t  = longint'($urandom_range(0, 800 * K));
    if ($urandom_range(0, 9) == 0) t = -t;
    nv = ($urandom_range(0, 9) < 7) ? $urandom_range(3, 5) : $urandom_range(1, 7);
    spread = longint'($urandom_range(1, 64)) * K;
    w = 0;
    for (int i = 0; i < 3; i++) begin
      centre[i] = aim_origin[i] + ((aim_dir[i] * t) >>> 30);
      nrm[i]    = aim_dir[i] >>> 18;
      w         = w + ((nrm[i] * centre[i]) >>> 12);
    end
    send(mk_item(rpfi_pkg::OP_PLANE, nrm[0], nrm[1], nrm[2], w, $urandom_range(0, 9) == 0,
                 $urandom_range(0, 1)));
    for (int k = 0; k < nv; k++) begin
      send(mk_item(rpfi_pkg::OP_VERTEX,
                   centre[0] + $signed($urandom_range(0, 2 * spread)) - spread,
                   centre[1] + $signed($urandom_range(0, 2 * spread)) - spread,
                   centre[2] + $signed($urandom_range(0, 2 * spread)) - spread,
                   $urandom, $urandom_range(0, 1), k == nv - 1));
    end
  endtask

  // Mostly aimed polygons, the rest raw noise.
  task automatic random_phase(int count);
    int start;
    start = sent;
    while (sent - start < count) begin
      if ($urandom_range(0, 99) < 80) begin
        send_polygon();
      end else begin
        send(mk_item($urandom_range(0, 1), $signed($urandom), $signed($urandom),
                     $signed($urandom), $signed($urandom), $urandom_range(0, 1),
                     $urandom_range(0, 1)));
      end
    end
  endtask

  task automatic directed();
    // Plain hit at distance ten.
    send(mk_item(rpfi_pkg::OP_PLANE, K, 0, 0, 10 * K, 0, 0));
    send(mk_item(rpfi_pkg::OP_VERTEX, 10 * K, -5 * K, -5 * K, 0, 0, 0));
    send(mk_item(rpfi_pkg::OP_VERTEX, 10 * K, 5 * K, -5 * K, 0, 0, 0));
    send(mk_item(rpfi_pkg::OP_VERTEX, 10 * K, 0, 5 * K, 0, 0, 1));
    // Same polygon marked not solid.
    send(mk_item(rpfi_pkg::OP_PLANE, K, 0, 0, 10 * K, 1, 0));
    send(mk_item(rpfi_pkg::OP_VERTEX, 10 * K, -5 * K, -5 * K, 0, 0, 0));
    send(mk_item(rpfi_pkg::OP_VERTEX, 10 * K, 5 * K, -5 * K, 0, 0, 0));
    send(mk_item(rpfi_pkg::OP_VERTEX, 10 * K, 0, 5 * K, 0, 0, 1));
    // Plane behind the origin is never crossed.
    send(mk_item(rpfi_pkg::OP_PLANE, K, 0, 0, -10 * K, 0, 0));
    send(mk_item(rpfi_pkg::OP_VERTEX, -10 * K, -5 * K, -5 * K, 0, 0, 0));
    send(mk_item(rpfi_pkg::OP_VERTEX, -10 * K, 5 * K, -5 * K, 0, 0, 0));
    send(mk_item(rpfi_pkg::OP_VERTEX, -10 * K, 0, 5 * K, 0, 0, 1));
    // Plane touching the origin; the hit at zero distance is too close.
    send(mk_item(rpfi_pkg::OP_PLANE, K, 0, 0, 0, 0, 0));
    send(mk_item(rpfi_pkg::OP_VERTEX, 0, -5 * K, -5 * K, 0, 0, 0));
    send(mk_item(rpfi_pkg::OP_VERTEX, 0, 5 * K, -5 * K, 0, 0, 0));
    send(mk_item(rpfi_pkg::OP_VERTEX, 0, 0, 5 * K, 0, 0, 1));
    // Closing flag on a plane is ignored; then one- and two-vertex polygons.
    send(mk_item(rpfi_pkg::OP_PLANE, K, 0, 0, 20 * K, 0, 1));
    send(mk_item(rpfi_pkg::OP_VERTEX, 20 * K, 0, 0, 0, 0, 1));
    send(mk_item(rpfi_pkg::OP_VERTEX, 20 * K, 1 * K, 0, 0, 0, 0));
    send(mk_item(rpfi_pkg::OP_VERTEX, 20 * K, 0, 1 * K, 0, 0, 1));
    // Vertices with no new plane reuse the last plane decision; a flat triangle along the ray.
    send(mk_item(rpfi_pkg::OP_VERTEX, 20 * K, 0, 0, 0, 0, 0));
    send(mk_item(rpfi_pkg::OP_VERTEX, 30 * K, 0, 0, 0, 0, 0));
    send(mk_item(rpfi_pkg::OP_VERTEX, 40 * K, 0, 0, 0, 0, 1));
    // Field extremes.
    send(mk_item(rpfi_pkg::OP_PLANE, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh8000_0000,
                 0, 0));
    send(mk_item(rpfi_pkg::OP_VERTEX, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                 32'sh7FFF_FFFF, 1, 0));
    send(mk_item(rpfi_pkg::OP_VERTEX, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                 0, 0, 0));
    send(mk_item(rpfi_pkg::OP_VERTEX, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                 0, 0, 1));
  endtask

  initial begin
    longint diag, half, small_o;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    out_ready   <= 1'b0;
    steady       = 1'b0;
    cycle_count <= 0;
    sent         = 0;
    aim_origin   = '{0, 0, 0};
    aim_dir      = '{longint'(32'sh4000_0000), 0, 0};
    diag         = 619925131;
    half         = 759250125;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset ray first, then a run of settings.
    directed();
    random_phase(PHASE_ITEMS - 30);
    for (int ph = 1; ph <= 7; ph++) begin
      settle();
      small_o = 1 << 20;
      case (ph)
        1: set_ray($signed($urandom_range(0, 2 * small_o)) - small_o, 0, 0,
                   0, 32'sh4000_0000, 0, 0, rpfi_pkg::T_SAT);
        2: set_ray(0, $signed($urandom_range(0, 2 * small_o)) - small_o, 0,
                   0, 0, -longint'(32'sh4000_0000), 5 * K, 200 * K);
        3: set_ray($signed($urandom_range(0, 2 * small_o)) - small_o,
                   $signed($urandom_range(0, 2 * small_o)) - small_o, 0,
                   $urandom_range(0, 1) ? diag : -diag, $urandom_range(0, 1) ? diag : -diag,
                   $urandom_range(0, 1) ? diag : -diag, 0, 600 * K);
        4: set_ray(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                   -longint'(32'sh4000_0000), 0, 0, 0, rpfi_pkg::T_SAT);
        5: set_ray(0, 0, 0, 32'sh4000_0000, 0, 0, 500 * K, 100 * K);
        6: begin
          steady = 1'b1;
          set_ray(0, 0, 0, half, half, 0, 1, rpfi_pkg::T_SAT);
        end
        default: begin
          steady = 1'b0;
          set_ray(0, 0, 0, 32'sh4000_0000, 0, 0, 0, 20 * K);
        end
      endcase
      random_phase(PHASE_ITEMS);
    end
    settle();

    if (errors == 0 && pending == 0) begin
      $display("PASS ray_polygon_fan_intersect");
    end else begin
      $display("FAIL ray_polygon_fan_intersect");
    end
    $finish;
  end

endmodule

@@ ray_polygon_fan_intersect.f @@
rtl/rpfi_pkg.sv
rtl/ray_polygon_fan_intersect.sv
dv/ray_polygon_fan_intersect_checker.sv
dv/ray_polygon_fan_intersect_test.sv
